FILE: sv/ksif_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksif_pkg
// Shared types, widths and the set-1 scancode map for the keyboard input FIFO.
// ----------------------------------------------------------------------------
package ksif_pkg;

   localparam int FIFO_DEPTH_DEF = 64;
   localparam int CODE_W         = 8;
   localparam int LEN_W          = 16;
   localparam int CHAR_W         = 7;
   localparam int COUNT_W        = 7;
   localparam int REQ_DATA_W     = 24;
   localparam int RSP_DATA_W     = 16;

   // Result payload source select
   typedef enum logic [1:0] {
      OUT_ECHO  = 2'd0,
      OUT_REPLY = 2'd1,
      OUT_DATA  = 2'd2
   } out_sel_type;

   // Controller to datapath commands
   typedef struct packed {
      logic        capture;
      logic        push;
      logic        load_count;
      logic        pop;
      logic        out_load;
      out_sel_type out_sel;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic kind;
      logic mapped;
      logic full;
      logic empty_read;
      logic last_pop;
      logic out_free;
   } status_type;

   // Set-1 press code to ASCII; zero means unmapped
   function automatic logic [CHAR_W-1:0] key_to_ascii(input logic [6:0] code);
      logic [CHAR_W-1:0] ch;
      case (code)
         7'h02: ch = 7'h31;  7'h03: ch = 7'h32;  7'h04: ch = 7'h33;
         7'h05: ch = 7'h34;  7'h06: ch = 7'h35;  7'h07: ch = 7'h36;
         7'h08: ch = 7'h37;  7'h09: ch = 7'h38;  7'h0A: ch = 7'h39;
         7'h0B: ch = 7'h30;
         7'h10: ch = 7'h71;  7'h11: ch = 7'h77;  7'h12: ch = 7'h65;
         7'h13: ch = 7'h72;  7'h14: ch = 7'h74;  7'h15: ch = 7'h79;
         7'h16: ch = 7'h75;  7'h17: ch = 7'h69;  7'h18: ch = 7'h6F;
         7'h19: ch = 7'h70;
         7'h1C: ch = 7'h0A;
         7'h1E: ch = 7'h61;  7'h1F: ch = 7'h73;  7'h20: ch = 7'h64;
         7'h21: ch = 7'h66;  7'h22: ch = 7'h67;  7'h23: ch = 7'h68;
         7'h24: ch = 7'h6A;  7'h25: ch = 7'h6B;  7'h26: ch = 7'h6C;
         7'h2C: ch = 7'h7A;  7'h2D: ch = 7'h78;  7'h2E: ch = 7'h63;
         7'h2F: ch = 7'h76;  7'h30: ch = 7'h62;  7'h31: ch = 7'h6E;
         7'h32: ch = 7'h6D;
         7'h39: ch = 7'h20;
         default: ch = '0;
      endcase
      return ch;
   endfunction

endpackage

FILE: sv/ksif_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksif_ctrl
// Controller state machine: takes one request beat at a time, decides drop,
// push, empty reply or a read run, and paces result beats.
// ----------------------------------------------------------------------------
module ksif_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  ksif_pkg::status_type sts,
   output ksif_pkg::cmd_type    cmd
);
   import ksif_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_EVAL    = 6'b000010,
      ST_PUSH    = 6'b000100,
      ST_REPLY   = 6'b001000,
      ST_RD_ADDR = 6'b010000,
      ST_RD_OUT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in       = state_ff;
      req_tready     = 1'b0;
      cmd.capture    = 1'b0;
      cmd.push       = 1'b0;
      cmd.load_count = 1'b0;
      cmd.pop        = 1'b0;
      cmd.out_load   = 1'b0;
      cmd.out_sel    = OUT_ECHO;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (!sts.kind) begin
               // drop releases, unmapped codes and keys that find no room
               if (sts.mapped && !sts.full) begin
                  state_in = ST_PUSH;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (sts.empty_read) begin
               state_in = ST_REPLY;
            end else begin
               cmd.load_count = 1'b1;
               state_in       = ST_RD_ADDR;
            end
         end
         ST_PUSH: begin
            if (sts.out_free) begin
               cmd.push     = 1'b1;
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_ECHO;
               state_in     = ST_IDLE;
            end
         end
         ST_REPLY: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_REPLY;
               state_in     = ST_IDLE;
            end
         end
         ST_RD_ADDR: begin
            // let the store read settle on the head entry
            state_in = ST_RD_OUT;
         end
         ST_RD_OUT: begin
            if (sts.out_free) begin
               cmd.pop      = 1'b1;
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_DATA;
               if (sts.last_pop) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sv/ksif_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksif_dpath
// Datapath: request capture, scancode map, character store with pointers and
// fill level, read run counter and the result output register.
// ----------------------------------------------------------------------------
module ksif_dpath #(
   parameter int FIFO_DEPTH = ksif_pkg::FIFO_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [ksif_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ksif_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tuser,
   output logic                              rsp_tlast,
   input  ksif_pkg::cmd_type                 cmd,
   output ksif_pkg::status_type              sts
);
   import ksif_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

   // Captured request
   logic              kind_ff;
   logic [CODE_W-1:0] code_ff;
   logic [LEN_W-1:0]  length_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff   <= req_tuser;
         code_ff   <= req_tdata[CODE_W-1:0];
         length_ff <= req_tdata[CODE_W +: LEN_W];
      end
   end

   // Map the press code and size the read
   logic [CHAR_W-1:0] echo_char;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  take_n;

   assign echo_char = key_to_ascii(code_ff[6:0]);
   assign take_n    = (length_ff < LEN_W'(fill_ff)) ? CNT_W'(length_ff) : fill_ff;

   // Pointers and fill level
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;

   always_comb begin
      rd_ptr_in = cmd.pop  ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      wr_ptr_in = cmd.push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      fill_in   = fill_ff;
      if (cmd.push) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Character store: one write port, one registered read port
   logic [CHAR_W-1:0] store_mem [FIFO_DEPTH];
   logic [CHAR_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         store_mem[wr_ptr_ff] <= echo_char;
      end
      rdata_ff <= store_mem[rd_ptr_in];
   end

   // Read run size and beats left
   logic [CNT_W-1:0] run_n_ff;
   logic [CNT_W-1:0] remain_ff, remain_in;

   always_comb begin
      remain_in = remain_ff;
      if (cmd.load_count) begin
         remain_in = take_n;
      end else if (cmd.pop) begin
         remain_in = remain_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
      end else begin
         remain_ff <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_count) begin
         run_n_ff <= take_n;
      end
   end

   // Result output register
   logic               out_valid_ff;
   logic               out_source_ff;
   logic [CHAR_W-1:0]  out_char_ff;
   logic [COUNT_W-1:0] out_count_ff;
   logic               out_last_ff;
   logic               out_free;

   assign out_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         case (cmd.out_sel)
            OUT_ECHO: begin
               out_source_ff <= 1'b0;
               out_char_ff   <= echo_char;
               out_count_ff  <= '0;
               out_last_ff   <= 1'b1;
            end
            OUT_REPLY: begin
               out_source_ff <= 1'b1;
               out_char_ff   <= '0;
               out_count_ff  <= '0;
               out_last_ff   <= 1'b1;
            end
            OUT_DATA: begin
               out_source_ff <= 1'b1;
               out_char_ff   <= rdata_ff;
               out_count_ff  <= COUNT_W'(run_n_ff);
               out_last_ff   <= (remain_ff == CNT_W'(1));
            end
            default: begin
               out_source_ff <= 1'b1;
               out_char_ff   <= '0;
               out_count_ff  <= '0;
               out_last_ff   <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_source_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - CHAR_W - COUNT_W){1'b0}}, out_count_ff, out_char_ff};

   // Status to controller
   assign sts.kind       = kind_ff;
   assign sts.mapped     = !code_ff[CODE_W-1] && (echo_char != '0);
   assign sts.full       = (fill_ff == CNT_FULL);
   assign sts.empty_read = (take_n == '0);
   assign sts.last_pop   = (remain_ff == CNT_W'(1));
   assign sts.out_free   = out_free;

endmodule

FILE: sv/keyboard_scancode_input_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_scancode_input_fifo
// Set-1 scancode to ASCII translation into a ring FIFO, with read requests
// that pop a run of characters.
// ----------------------------------------------------------------------------
// A key press echo passes the EVAL and PUSH states before it is registered
// as a result beat. A read run passes EVAL, RD_ADDR and RD_OUT before its
// first character is registered, then one character per cycle while
// rsp_tready stays high. Requests are taken one at a time: a new request is
// accepted only once the controller is back in IDLE. The store has one read port.
// Reset clears pointers, fill level and all valid state; store contents are
// not cleared and hold nothing readable until written.
// ----------------------------------------------------------------------------
module keyboard_scancode_input_fifo #(
   parameter int FIFO_DEPTH = ksif_pkg::FIFO_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] scan_code, [23:8] read_length
   input  logic [ksif_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] kind
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [6:0] character, [13:7] read_count, [15:14] zero
   output logic [ksif_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [0] source
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);
   import ksif_pkg::*;

   cmd_type    cmd;
   status_type sts;

   // Controller
   ksif_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Datapath
   ksif_dpath #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

FILE: sv/ksif_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksif_assertions
// Port-level checks for the keyboard input FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module ksif_assertions (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [ksif_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic                              rsp_tuser,
   input logic                              rsp_tlast
);
   import ksif_pkg::*;

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // One request at a time: no accept in the cycle after an accept
   a_req_single: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted back to back");

   // Echo beats are single and carry no count
   a_echo_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast
         && (rsp_tdata[CHAR_W +: COUNT_W] == '0) && (rsp_tdata[CHAR_W-1:0] != '0))
      else $error("malformed echo beat");

   // Empty reply is a single zero beat; popped data is never zero
   a_read_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         ((rsp_tdata[CHAR_W +: COUNT_W] == '0) && rsp_tlast
            && (rsp_tdata[CHAR_W-1:0] == '0))
         || ((rsp_tdata[CHAR_W +: COUNT_W] != '0) && (rsp_tdata[CHAR_W-1:0] != '0)))
      else $error("malformed read beat");

endmodule

bind keyboard_scancode_input_fifo ksif_assertions u_ksif_assertions (.*);
